// ===== sv/div64_pkg.sv =====
// ----------------------------------------------------------------------------
// div64_pkg
// Shared types and constants for the pipelined restoring divider.
// ----------------------------------------------------------------------------
package div64_pkg;

  localparam int unsigned PORT_WIDTH = 64;

  typedef struct packed {
    logic valid;
    logic neg_q;
    logic neg_r;
    logic dbz;
  } ctl_t;

endpackage

// ===== sv/div64_cell.sv =====
// ----------------------------------------------------------------------------
// div64_cell
// One restoring division step: shift in the next dividend bit, trial
// subtract the divisor, keep or restore, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module div64_cell #(
  parameter int unsigned W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  div64_pkg::ctl_t     ctl_in,
  input  logic [W-1:0]        r_in,
  input  logic [W-1:0]        n_in,
  input  logic [W-1:0]        q_in,
  input  logic [W-1:0]        d_in,
  output div64_pkg::ctl_t     ctl_out,
  output logic [W-1:0]        r_out,
  output logic [W-1:0]        n_out,
  output logic [W-1:0]        q_out,
  output logic [W-1:0]        d_out
);

  logic [W-1:0] rs;
  logic [W:0]   diff;
  logic         ge;

  assign rs   = {r_in[W-2:0], n_in[W-1]};
  assign diff = {1'b0, rs} - {1'b0, d_in};
  assign ge   = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    r_out <= ge ? diff[W-1:0] : rs;
    q_out <= {q_in[W-2:0], ge};
    n_out <= {n_in[W-2:0], 1'b0};
    d_out <= d_in;
  end

endmodule

// ===== sv/div64_fix.sv =====
// ----------------------------------------------------------------------------
// div64_fix
// Output stage: restore signs, force zero results on a zero divisor and
// register the result word with its strobe.
// ----------------------------------------------------------------------------
module div64_fix #(
  parameter int unsigned W = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  div64_pkg::ctl_t                      ctl_in,
  input  logic [W-1:0]                         q_in,
  input  logic [W-1:0]                         r_in,
  output logic                                 done,
  output logic [div64_pkg::PORT_WIDTH-1:0]     quotient,
  output logic [div64_pkg::PORT_WIDTH-1:0]     remainder,
  output logic                                 divide_by_zero
);

  logic [W-1:0] q_neg;
  logic [W-1:0] r_neg;
  logic [W-1:0] q_next;
  logic [W-1:0] r_next;

  assign q_neg = ~q_in + 1'b1;
  assign r_neg = ~r_in + 1'b1;

  always_comb begin
    if (ctl_in.dbz) begin
      q_next = '0;
      r_next = '0;
    end else begin
      q_next = ctl_in.neg_q ? q_neg : q_in;
      r_next = ctl_in.neg_r ? r_neg : r_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient       <= div64_pkg::PORT_WIDTH'(q_next);
    remainder      <= div64_pkg::PORT_WIDTH'(r_next);
    divide_by_zero <= ctl_in.dbz;
  end

endmodule

// ===== sv/divider_64bit_signed_unsigned.sv =====
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned
// Pipelined restoring divider, signed or unsigned, quotient and remainder.
// ----------------------------------------------------------------------------
// A new word is taken on every cycle that start is high; busy is always low.
// Each word comes out on the result ports marked by done for one cycle, in the
// order taken, after one operand stage, the row of DATA_WIDTH cells, each of
// which resolves one quotient bit per cycle, and one sign-fix stage. The
// receiver cannot stall the pipe: a result must be taken in the cycle done
// is high. A zero divisor gives zero quotient and remainder with
// divide_by_zero set; in signed mode the remainder follows the sign of the
// dividend.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cmd,
  input  logic [div64_pkg::PORT_WIDTH-1:0]     dividend,
  input  logic [div64_pkg::PORT_WIDTH-1:0]     divisor,
  output logic                                 done,
  output logic [div64_pkg::PORT_WIDTH-1:0]     quotient,
  output logic [div64_pkg::PORT_WIDTH-1:0]     remainder,
  output logic                                 divide_by_zero
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0]    n_w;
  logic [W-1:0]    d_w;
  logic            n_sgn;
  logic            d_sgn;
  logic [W-1:0]    n_mag;
  logic [W-1:0]    d_mag;

  div64_pkg::ctl_t ctl_s [W+1];
  logic [W-1:0]    r_s   [W+1];
  logic [W-1:0]    n_s   [W+1];
  logic [W-1:0]    q_s   [W+1];
  logic [W-1:0]    d_s   [W+1];

  assign busy  = 1'b0;

  assign n_w   = dividend[W-1:0];
  assign d_w   = divisor[W-1:0];
  assign n_sgn = cmd & n_w[W-1];
  assign d_sgn = cmd & d_w[W-1];
  assign n_mag = n_sgn ? (~n_w + 1'b1) : n_w;
  assign d_mag = d_sgn ? (~d_w + 1'b1) : d_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else begin
      ctl_s[0].valid <= start;
      ctl_s[0].neg_q <= n_sgn ^ d_sgn;
      ctl_s[0].neg_r <= n_sgn;
      ctl_s[0].dbz   <= (d_w == '0);
    end
  end

  always_ff @(posedge clk) begin
    r_s[0] <= '0;
    n_s[0] <= n_mag;
    q_s[0] <= '0;
    d_s[0] <= d_mag;
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    div64_cell #(
      .W (W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[i]),
      .r_in    (r_s[i]),
      .n_in    (n_s[i]),
      .q_in    (q_s[i]),
      .d_in    (d_s[i]),
      .ctl_out (ctl_s[i+1]),
      .r_out   (r_s[i+1]),
      .n_out   (n_s[i+1]),
      .q_out   (q_s[i+1]),
      .d_out   (d_s[i+1])
    );
  end

  div64_fix #(
    .W (W)
  ) u_fix (
    .clk            (clk),
    .rst            (rst),
    .ctl_in         (ctl_s[W]),
    .q_in           (q_s[W]),
    .r_in           (r_s[W]),
    .done           (done),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

endmodule

// ===== sim/divider_64bit_signed_unsigned_test.sv =====
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned_test
// Self-checking bench for the pipelined signed/unsigned 64-bit divider.
// ----------------------------------------------------------------------------
// Each accepted word is divided by the bench's own quotient/remainder model.
// The result is queued in issue order, and every done strobe is checked
// against the oldest entry in that queue. A directed set covers the corner
// operands: zero divisor, most negative over minus one, extreme magnitudes
// and all sign combinations. Random words follow in three phases with
// different sender gaps, and the pipe drains fully between phases.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = div64_pkg::PORT_WIDTH;
  localparam int unsigned DRAIN_CYCLES = W + 16;
  localparam logic CMD_UNSIGNED = 1'b0;
  localparam logic CMD_SIGNED = 1'b1;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  typedef struct {
    logic           sgn;
    logic [W-1:0]   num;
    logic [W-1:0]   den;
  } div_word_t;

  typedef struct {
    logic [W-1:0]   quo;
    logic [W-1:0]   rem;
    logic           dbz;
  } quo_rem_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  logic           cmd = 1'b0;
  logic [W-1:0]   dividend = '0;
  logic [W-1:0]   divisor = '0;
  logic           done;
  logic [W-1:0]   quotient;
  logic [W-1:0]   remainder;
  logic           divide_by_zero;

  div_word_t      words_to_send[$];
  quo_rem_t       quo_rem_due[$];
  logic           stalled = 1'b0;
  int unsigned    send_idle_pct = 0;
  int unsigned    n_fail = 0;
  int unsigned    n_checked = 0;
  int unsigned    n_signed = 0;
  int unsigned    n_dbz = 0;
  quo_rem_t       want;

  divider_64bit_signed_unsigned u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .dividend       (dividend),
    .divisor        (divisor),
    .done           (done),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  always #4 clk = ~clk;

  function automatic logic [W-1:0] twos_neg(logic [W-1:0] v);
    return ~v + 1'b1;
  endfunction

  function automatic quo_rem_t divide_word(div_word_t w);
    quo_rem_t     res;
    logic         num_neg;
    logic         den_neg;
    logic [W-1:0] mag_num;
    logic [W-1:0] mag_den;
    res.dbz = (w.den == '0);
    res.quo = '0;
    res.rem = '0;
    if (!res.dbz) begin
      if (w.sgn == CMD_SIGNED) begin
        num_neg = w.num[W-1];
        den_neg = w.den[W-1];
        mag_num = num_neg ? twos_neg(w.num) : w.num;
        mag_den = den_neg ? twos_neg(w.den) : w.den;
        res.quo = mag_num / mag_den;
        res.rem = mag_num % mag_den;
        if (num_neg != den_neg) res.quo = twos_neg(res.quo);
        if (num_neg) res.rem = twos_neg(res.rem);
      end else begin
        res.quo = w.num / w.den;
        res.rem = w.num % w.den;
      end
    end
    return res;
  endfunction

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    int unsigned  kind;
    v = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind >= 4 && kind <= 6) begin
      v = v >> $urandom_range(W - 1);
    end else if (kind == 7) begin
      v = ~(v >> $urandom_range(W - 1));
    end else if (kind == 8) begin
      case ($urandom_range(4))
        0: v = '0;
        1: v = W'(1);
        2: v = ALL_ONES;
        3: v = MOST_NEG;
        default: v = MOST_POS;
      endcase
    end else if (kind == 9) begin
      v = W'($urandom_range(15));
    end
    return v;
  endfunction

  task automatic queue_word(logic sgn, logic [W-1:0] num, logic [W-1:0] den);
    div_word_t w;
    w.sgn = sgn;
    w.num = num;
    w.den = den;
    words_to_send.push_back(w);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) queue_word(1'($urandom_range(1)), pick_operand(), pick_operand());
  endtask

  task automatic drain_pipe();
    while (words_to_send.size() != 0 || quo_rem_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_fail(string what);
    n_fail++;
    if (n_fail <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Drive the next word at the falling edge; hold it while the block is busy.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && stalled) begin
      start <= 1'b1;
    end else if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      start    <= 1'b1;
      cmd      <= words_to_send[0].sgn;
      dividend <= words_to_send[0].num;
      divisor  <= words_to_send[0].den;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stalled <= 1'b0;
    end else begin
      stalled <= start && busy;
      if (start && !busy) begin
        quo_rem_due.push_back(divide_word('{sgn: cmd, num: dividend, den: divisor}));
        words_to_send.pop_front();
        if (cmd == CMD_SIGNED) n_signed++;
        if (divisor == '0) n_dbz++;
      end
      if (done) begin
        if (quo_rem_due.size() == 0) begin
          report_fail($sformatf("result with nothing pending: q=%h r=%h dbz=%b",
                                quotient, remainder, divide_by_zero));
        end else begin
          want = quo_rem_due.pop_front();
          n_checked++;
          if (quotient !== want.quo || remainder !== want.rem ||
              divide_by_zero !== want.dbz)
            report_fail($sformatf("mismatch: want q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b",
                                  want.quo, want.rem, want.dbz,
                                  quotient, remainder, divide_by_zero));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[divider_64bit_signed_unsigned] ERROR");
    $finish;
  end

  initial begin
    queue_word(CMD_UNSIGNED, '0, W'(1));
    queue_word(CMD_UNSIGNED, ALL_ONES, W'(1));
    queue_word(CMD_UNSIGNED, ALL_ONES, ALL_ONES);
    queue_word(CMD_UNSIGNED, ALL_ONES, '0);
    queue_word(CMD_UNSIGNED, '0, '0);
    queue_word(CMD_UNSIGNED, W'(5), W'(7));
    queue_word(CMD_UNSIGNED, ALL_ONES, W'(2));
    queue_word(CMD_UNSIGNED, MOST_NEG, W'(3));
    queue_word(CMD_UNSIGNED, 64'h1234_5678_9abc_def0, ALL_ONES);
    queue_word(CMD_UNSIGNED, ALL_ONES, MOST_NEG);
    queue_word(CMD_SIGNED, MOST_NEG, ALL_ONES);
    queue_word(CMD_SIGNED, MOST_NEG, W'(1));
    queue_word(CMD_SIGNED, MOST_NEG, MOST_NEG);
    queue_word(CMD_SIGNED, MOST_POS, ALL_ONES);
    queue_word(CMD_SIGNED, MOST_POS, MOST_NEG);
    queue_word(CMD_SIGNED, twos_neg(W'(7)), W'(2));
    queue_word(CMD_SIGNED, W'(7), twos_neg(W'(2)));
    queue_word(CMD_SIGNED, twos_neg(W'(7)), twos_neg(W'(2)));
    queue_word(CMD_SIGNED, W'(7), W'(2));
    queue_word(CMD_SIGNED, MOST_NEG, '0);
    queue_word(CMD_SIGNED, ALL_ONES, '0);
    queue_word(CMD_SIGNED, twos_neg(W'(3)), W'(5));
    send_idle_pct = 12;
    queue_random(600);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pause the sender until the pipe is empty, then switch gap rate.
    drain_pipe();
    send_idle_pct = 76;
    queue_random(400);
    drain_pipe();
    send_idle_pct = 0;
    queue_random(880);
    drain_pipe();

    repeat (DRAIN_CYCLES) @(posedge clk);
    n_fail += quo_rem_due.size();
    $display("Checked %0d divide results: %0d signed, %0d unsigned, %0d zero divisor",
             n_checked, n_signed, n_checked - n_signed, n_dbz);
    $display("Sender gaps: 12%% then 76%% then back-to-back; %0d failures", n_fail);
    if (n_fail == 0) begin
      $display("[divider_64bit_signed_unsigned] OK");
    end else begin
      $display("[divider_64bit_signed_unsigned] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/div64_pkg.sv
sv/div64_cell.sv
sv/div64_fix.sv
sv/divider_64bit_signed_unsigned.sv
sim/divider_64bit_signed_unsigned_test.sv
